FILE: rtl/core/json_value_span_finder_assert.svh
// assertion helpers, clocked on clk and disabled during reset
`ifndef JSON_VALUE_SPAN_FINDER_ASSERT_SVH
`define JSON_VALUE_SPAN_FINDER_ASSERT_SVH

// condition holds at every edge
`define JVSF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define JVSF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JVSF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/jvsf_pkg.sv
package jvsf_pkg;

	localparam int LEN_W          = 28;
	localparam int NEST_DEPTH_DEF = 64;

	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0] MAX_RESET = 28'd134217728;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;

	typedef enum logic [1:0] {
		MODE_STRING    = 2'd0,
		MODE_COMPOSITE = 2'd1,
		MODE_PRIMITIVE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EOF_BEFORE = 3'd1,
		ST_EOF_INSIDE = 3'd2,
		ST_MISMATCH   = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_TOO_LONG   = 3'd5
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic push_bit;
	} stack_ctl_t;

	typedef struct packed {
		logic             consumed;
		logic             done;
		logic [LEN_W-1:0] length;
		status_t          status;
	} result_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB ||
			c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE;
	endfunction

endpackage

FILE: rtl/core/jvsf_in_if.sv
interface jvsf_in_if;
	import jvsf_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_value;
	logic       end_of_input;

	modport source (output valid, output data_byte, output start_value,
		output end_of_input, input ready);
	modport sink (input valid, input data_byte, input start_value,
		input end_of_input, output ready);

endinterface

FILE: rtl/core/jvsf_out_if.sv
interface jvsf_out_if;
	import jvsf_pkg::*;

	logic             valid;
	logic             ready;
	logic             byte_consumed;
	logic             value_done;
	logic [LEN_W-1:0] value_length;
	status_t          status;

	modport source (output valid, output byte_consumed, output value_done,
		output value_length, output status, input ready);
	modport sink (input valid, input byte_consumed, input value_done,
		input value_length, input status, output ready);

endinterface

FILE: rtl/core/jvsf_closer_cell.sv
module jvsf_closer_cell (
	input  logic                clk,
	input  jvsf_pkg::stack_ctl_t ctl,
	input  logic                from_above,
	input  logic                from_below,
	output logic                bit_q
);
	import jvsf_pkg::*;

	// push shifts toward the bottom, pop shifts toward the top
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			bit_q <= from_above;
		end else if (ctl.pop) begin
			bit_q <= from_below;
		end
	end

endmodule

FILE: rtl/core/jvsf_scanner.sv
`include "json_value_span_finder_assert.svh"

module jvsf_scanner #(
	parameter int NEST_DEPTH = jvsf_pkg::NEST_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [7:0]                 data_byte,
	input  logic                       start_value,
	input  logic                       end_of_input,
	input  logic [jvsf_pkg::LEN_W-1:0] max_bytes,
	output jvsf_pkg::result_t          res
);
	import jvsf_pkg::*;

	localparam int LVL_W = $clog2(NEST_DEPTH + 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(NEST_DEPTH);

	logic             active_q, active_n;
	mode_t            mode_q, mode_n;
	logic             in_str_q, in_str_n;
	logic             esc_q, esc_n;
	logic [LVL_W-1:0] level_q, level_n;
	logic [LEN_W-1:0] len_q, len_n;

	logic             consumed, done;
	status_t          st;
	stack_ctl_t       ctl_c, ctl;
	logic             cell_bit [NEST_DEPTH];

	logic [LEN_W:0]   len_inc;
	logic             over;
	logic [LEN_W-1:0] len_sat;
	logic             is_open, is_close, want;

	// closer stack: top of stack lives in cell 0
	for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
		logic above, below;
		if (i == 0) begin : g_head
			assign above = ctl.push_bit;
		end else begin : g_body
			assign above = cell_bit[i-1];
		end
		if (i == NEST_DEPTH - 1) begin : g_tail
			assign below = 1'b0;
		end else begin : g_mid
			assign below = cell_bit[i+1];
		end
		jvsf_closer_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.bit_q      (cell_bit[i])
		);
	end

	assign len_inc  = {1'b0, len_q} + (LEN_W+1)'(1);
	assign over     = len_inc > {1'b0, max_bytes};
	assign len_sat  = (len_q != LEN_MAX) ? len_inc[LEN_W-1:0] : len_q;
	assign is_open  = data_byte == CH_LBRACE || data_byte == CH_LBRACK;
	assign is_close = data_byte == CH_RBRACE || data_byte == CH_RBRACK;
	assign want     = data_byte == CH_RBRACK;

	always_comb begin
		consumed = 1'b0;
		done     = 1'b0;
		st       = ST_OK;
		ctl_c    = '{push: 1'b0, pop: 1'b0, push_bit: data_byte == CH_LBRACK};
		active_n = active_q;
		mode_n   = mode_q;
		in_str_n = in_str_q;
		esc_n    = esc_q;
		level_n  = level_q;
		len_n    = len_q;

		if (start_value) begin
			active_n = 1'b0;
			mode_n   = MODE_PRIMITIVE;
			in_str_n = 1'b0;
			esc_n    = 1'b0;
			level_n  = '0;
			len_n    = '0;
			if (end_of_input) begin
				done = 1'b1;
				st   = ST_EOF_BEFORE;
			end else begin
				active_n = 1'b1;
				consumed = 1'b1;
				len_n    = LEN_W'(1);
				if (data_byte == CH_QUOTE) begin
					mode_n   = MODE_STRING;
					in_str_n = 1'b1;
				end else if (is_open) begin
					mode_n     = MODE_COMPOSITE;
					ctl_c.push = 1'b1;
					level_n    = LVL_W'(1);
				end
				if (max_bytes == '0) begin
					done = 1'b1;
					st   = ST_TOO_LONG;
				end
			end
		end else if (active_q) begin
			if (mode_q == MODE_PRIMITIVE) begin
				if (end_of_input || is_delim(data_byte)) begin
					done = 1'b1;
				end else begin
					consumed = 1'b1;
					len_n    = len_sat;
					if (over) begin
						done = 1'b1;
						st   = ST_TOO_LONG;
					end
				end
			end else if (end_of_input) begin
				done = 1'b1;
				st   = ST_EOF_INSIDE;
			end else begin
				consumed = 1'b1;
				len_n    = len_sat;
				if (in_str_q) begin
					if (esc_q) begin
						esc_n = 1'b0;
					end else if (data_byte == CH_BSLASH) begin
						esc_n = 1'b1;
					end else if (data_byte == CH_QUOTE) begin
						in_str_n = 1'b0;
						if (mode_q == MODE_STRING) begin
							done = 1'b1;
						end
					end
				end else if (data_byte == CH_QUOTE) begin
					in_str_n = 1'b1;
					esc_n    = 1'b0;
				end else if (is_open) begin
					if (level_q == LVL_FULL) begin
						done = 1'b1;
						st   = ST_OVERFLOW;
					end else begin
						ctl_c.push = 1'b1;
						level_n    = level_q + LVL_W'(1);
					end
				end else if (is_close) begin
					if (level_q == '0 || cell_bit[0] != want) begin
						done = 1'b1;
						st   = ST_MISMATCH;
					end else begin
						ctl_c.pop = 1'b1;
						level_n   = level_q - LVL_W'(1);
						if (level_n == '0 && mode_q == MODE_COMPOSITE) begin
							done = 1'b1;
						end
					end
				end
				if (over && st == ST_OK) begin
					done = 1'b1;
					st   = ST_TOO_LONG;
				end
			end
		end

		if (done) begin
			active_n = 1'b0;
			mode_n   = MODE_PRIMITIVE;
			in_str_n = 1'b0;
			esc_n    = 1'b0;
			level_n  = '0;
		end

		res.consumed = consumed;
		res.done     = done;
		res.length   = (start_value || consumed || done) ? len_n : '0;
		res.status   = st;
	end

	always_comb begin
		ctl      = ctl_c;
		ctl.push = ctl_c.push && fire;
		ctl.pop  = ctl_c.pop && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_q   <= MODE_PRIMITIVE;
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			level_q  <= '0;
			len_q    <= '0;
		end else if (fire) begin
			active_q <= active_n;
			mode_q   <= mode_n;
			in_str_q <= in_str_n;
			esc_q    <= esc_n;
			level_q  <= level_n;
			len_q    <= len_n;
		end
	end

	`JVSF_ASSERT_ALWAYS(a_level_bound, level_q <= LVL_FULL, "nesting level beyond stack depth")
	`JVSF_ASSERT_IMP(a_idle_clean, !active_q, level_q == '0 && !in_str_q && !esc_q,
		"idle scanner holds value state")
	`JVSF_ASSERT_IMP(a_esc_in_str, esc_q, in_str_q, "escape pending outside a string")
	`JVSF_ASSERT_NXT(a_done_idle, fire && res.done, !active_q, "scanner active after value end")

endmodule

FILE: rtl/core/jvsf_out_buf.sv
`include "json_value_span_finder_assert.svh"

module jvsf_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jvsf_pkg::result_t res,
	output logic              can_take,
	jvsf_out_if.source        out_ch
);
	import jvsf_pkg::*;

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    pop;

	assign can_take = !skid_v_q;
	assign pop      = out_v_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.byte_consumed = out_q.consumed;
	assign out_ch.value_done    = out_q.done;
	assign out_ch.value_length  = out_q.length;
	assign out_ch.status        = out_q.status;

	`JVSF_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid entry without output entry")
	`JVSF_ASSERT_NXT(a_stall_to_skid, push && out_v_q && !out_ch.ready, skid_v_q,
		"stalled transaction not parked")
	`JVSF_ASSERT_NXT(a_skid_drains, skid_v_q && out_ch.ready, out_v_q && !skid_v_q,
		"skid entry not moved forward")

endmodule

FILE: rtl/core/json_value_span_finder.sv
// json value span finder
//
// in_ch carries one text byte per transaction with start_value and
// end_of_input flags; out_ch returns exactly one result transaction per input
// transaction, in order: byte_consumed, value_done, value_length, status.
// cfg_we/cfg_wdata write max_value_bytes; write it only while idle.
//
// throughput: one byte per cycle while in_ch is ready. each byte updates the
// scan flags, the 28-bit length counter and the closer stack; the stack is
// a row of NEST_DEPTH one-bit cells shifting on push and pop, top in cell 0.
// out_ch is driven from a registered output stage, backed by a skid register.
//
// reset clears the scan state, makes the block idle and sets max_value_bytes
// to 2^27. stack cells are not reset; they are only read below the level.
// when out_ch stalls, one further result is parked in a skid register, so
// in_ch stays ready for one more transaction and then drops ready until the
// receiver takes the held result.
module json_value_span_finder #(
	parameter int NEST_DEPTH = jvsf_pkg::NEST_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [jvsf_pkg::LEN_W-1:0] cfg_wdata,
	jvsf_in_if.sink                    in_ch,
	jvsf_out_if.source                 out_ch
);
	import jvsf_pkg::*;

	logic [LEN_W-1:0] max_q;
	logic             can_take;
	logic             fire;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	assign in_ch.ready = can_take;
	assign fire        = in_ch.valid && can_take;

	jvsf_scanner #(
		.NEST_DEPTH (NEST_DEPTH)
	) u_scanner (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.data_byte    (in_ch.data_byte),
		.start_value  (in_ch.start_value),
		.end_of_input (in_ch.end_of_input),
		.max_bytes    (max_q),
		.res          (res)
	);

	jvsf_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.res      (res),
		.can_take (can_take),
		.out_ch   (out_ch)
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import jvsf_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 25;

	typedef struct {
		logic [7:0] c;
		logic       st;
		logic       eof;
	} text_item_t;

	class span_board;
		logic [LEN_W-1:0] limit;
		logic             active;
		mode_t            mode;
		logic             in_str;
		logic             esc;
		logic [63:0]      closers;
		int unsigned      level;
		logic [LEN_W-1:0] len;
		result_t          expected_spans[$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      ended;
		logic [7:0]       status_seen;

		function new();
			limit       = MAX_RESET;
			closers     = '0;
			len         = '0;
			errors      = 0;
			checked     = 0;
			ended       = 0;
			status_seen = '0;
			reset_scan();
		endfunction

		function void set_limit(logic [LEN_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return expected_spans.size();
		endfunction

		function void reset_scan();
			active = 1'b0;
			mode   = MODE_PRIMITIVE;
			in_str = 1'b0;
			esc    = 1'b0;
			level  = 0;
		endfunction

		function bit push_closer(logic [7:0] c);
			if (level >= NEST_DEPTH_DEF)
				return 1'b0;
			closers[level] = (c == CH_LBRACK);
			level++;
			return 1'b1;
		endfunction

		// true when the new length passes the limit
		function bit bump_length();
			logic [31:0] nxt;
			nxt = {4'b0, len} + 32'd1;
			if (len != LEN_MAX)
				len = nxt[LEN_W-1:0];
			return nxt > {4'b0, limit};
		endfunction

		function bit ends_primitive(logic [7:0] c);
			case (c)
				CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_COMMA, CH_RBRACK, CH_RBRACE: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void take_byte(logic [7:0] c, logic st, logic eof);
			result_t r;
			r        = '0;
			r.status = ST_OK;
			if (st) begin
				reset_scan();
				len = '0;
				if (eof) begin
					r.done   = 1'b1;
					r.status = ST_EOF_BEFORE;
				end else begin
					active     = 1'b1;
					r.consumed = 1'b1;
					if (c == CH_QUOTE) begin
						mode   = MODE_STRING;
						in_str = 1'b1;
					end else if (c == CH_LBRACE || c == CH_LBRACK) begin
						mode = MODE_COMPOSITE;
						void'(push_closer(c));
					end else begin
						mode = MODE_PRIMITIVE;
					end
					if (bump_length()) begin
						r.done   = 1'b1;
						r.status = ST_TOO_LONG;
					end
				end
			end else if (active) begin
				if (mode == MODE_PRIMITIVE) begin
					if (eof || ends_primitive(c)) begin
						r.done = 1'b1;
					end else begin
						r.consumed = 1'b1;
						if (bump_length()) begin
							r.done   = 1'b1;
							r.status = ST_TOO_LONG;
						end
					end
				end else if (eof) begin
					r.done   = 1'b1;
					r.status = ST_EOF_INSIDE;
				end else begin
					r.consumed = 1'b1;
					if (in_str) begin
						if (esc) begin
							esc = 1'b0;
						end else if (c == CH_BSLASH) begin
							esc = 1'b1;
						end else if (c == CH_QUOTE) begin
							in_str = 1'b0;
							if (mode == MODE_STRING)
								r.done = 1'b1;
						end
					end else if (c == CH_QUOTE) begin
						in_str = 1'b1;
						esc    = 1'b0;
					end else if (c == CH_LBRACE || c == CH_LBRACK) begin
						if (!push_closer(c)) begin
							r.done   = 1'b1;
							r.status = ST_OVERFLOW;
						end
					end else if (c == CH_RBRACE || c == CH_RBRACK) begin
						if (level == 0 || closers[level-1] != (c == CH_RBRACK)) begin
							r.done   = 1'b1;
							r.status = ST_MISMATCH;
						end else begin
							level--;
							if (level == 0 && mode == MODE_COMPOSITE)
								r.done = 1'b1;
						end
					end
					if (bump_length() && r.status == ST_OK) begin
						r.done   = 1'b1;
						r.status = ST_TOO_LONG;
					end
				end
			end
			if (r.done)
				reset_scan();
			r.length = (st || r.consumed || r.done) ? len : '0;
			expected_spans.insert(expected_spans.size(), r);
		endfunction

		task flag(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task match_result(logic consumed, logic done, logic [LEN_W-1:0] length, status_t status);
			result_t want;
			if (expected_spans.size() == 0) begin
				flag("result transaction with nothing outstanding");
				return;
			end
			want = expected_spans.pop_front();
			checked++;
			if (want.done)
				ended++;
			status_seen[want.status] = 1'b1;
			if (consumed !== want.consumed)
				flag($sformatf("result %0d byte_consumed %b, want %b", checked, consumed,
					want.consumed));
			if (done !== want.done)
				flag($sformatf("result %0d value_done %b, want %b", checked, done, want.done));
			if (length !== want.length)
				flag($sformatf("result %0d value_length %0d, want %0d", checked, length,
					want.length));
			if (status !== want.status)
				flag($sformatf("result %0d status %0d, want %0d", checked, status, want.status));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	jvsf_in_if  in_ch();
	jvsf_out_if out_ch();

	span_board    board;
	text_item_t   text_q[$];
	bit           idling;
	bit           hold_req;
	int unsigned  holds_done;
	int unsigned  input_stalls;
	int unsigned  limits_used;

	json_value_span_finder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void put_byte(logic [7:0] c, logic st = 1'b0, logic eof = 1'b0);
		text_item_t it;
		it.c   = c;
		it.st  = st;
		it.eof = eof;
		text_q.insert(text_q.size(), it);
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(0, 6))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_CR;
			3: return CH_TAB;
			4: return CH_COMMA;
			5: return CH_RBRACK;
			default: return CH_RBRACE;
		endcase
	endfunction

	function automatic logic [7:0] prim_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB ||
			c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE);
		return c;
	endfunction

	// anything that does not change the nesting or open a string
	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_LBRACE || c == CH_LBRACK ||
			c == CH_RBRACE || c == CH_RBRACK);
		return c;
	endfunction

	function automatic void put_text(int unsigned n);
		logic [7:0] c;
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				put_byte(CH_BSLASH);
				put_byte(8'($urandom_range(0, 255)));
			end else begin
				do c = 8'($urandom_range(0, 255));
				while (c == CH_QUOTE || c == CH_BSLASH);
				put_byte(c);
			end
		end
	endfunction

	function automatic void gen_primitive();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_LBRACE || c == CH_LBRACK);
		put_byte(c, 1'b1);
		repeat ($urandom_range(0, 6))
			put_byte(prim_char());
		case ($urandom_range(0, 9))
			6, 7: put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			8: ;
			default: put_byte(pick_delim());
		endcase
	endfunction

	function automatic void gen_string();
		put_byte(CH_QUOTE, 1'b1);
		put_text($urandom_range(0, 8));
		case ($urandom_range(0, 7))
			0: put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			1: ;
			default: put_byte(CH_QUOTE);
		endcase
	endfunction

	function automatic void gen_composite(int unsigned depth_cap);
		bit open_q[$];
		int r;
		bit b;
		b = 1'($urandom_range(0, 1));
		put_byte(b ? CH_LBRACK : CH_LBRACE, 1'b1);
		open_q.insert(open_q.size(), b);
		while (open_q.size() > 0) begin
			r = $urandom_range(0, 11);
			if (r <= 2 && open_q.size() < depth_cap) begin
				b = 1'($urandom_range(0, 1));
				put_byte(b ? CH_LBRACK : CH_LBRACE);
				open_q.insert(open_q.size(), b);
			end else if (r <= 4) begin
				put_byte(CH_QUOTE);
				put_text($urandom_range(0, 4));
				put_byte(CH_QUOTE);
			end else if (r <= 7) begin
				repeat ($urandom_range(1, 3))
					put_byte(filler_char());
			end else if (r <= 10) begin
				put_byte(open_q[$] ? CH_RBRACK : CH_RBRACE);
				open_q.delete(open_q.size() - 1);
			end else begin
				case ($urandom_range(0, 5))
					0: begin
						put_byte(open_q[$] ? CH_RBRACE : CH_RBRACK);
						return;
					end
					1: begin
						put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
						return;
					end
					2: return;
					default: put_byte(filler_char());
				endcase
			end
		end
	endfunction

	// fills the closer stack to the full depth, then overflows or unwinds
	function automatic void gen_deep(bit overflow);
		bit kinds[$];
		for (int i = 0; i < NEST_DEPTH_DEF; i++) begin
			kinds.insert(kinds.size(), 1'($urandom_range(0, 1)));
			put_byte(kinds[i] ? CH_LBRACK : CH_LBRACE, i == 0);
		end
		if (overflow)
			put_byte($urandom_range(0, 1) ? CH_LBRACK : CH_LBRACE);
		else
			while (kinds.size() > 0) begin
				put_byte(kinds[$] ? CH_RBRACK : CH_RBRACE);
				kinds.delete(kinds.size() - 1);
			end
	endfunction

	function automatic void gen_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			gen_primitive();
		end else if (r < 55) begin
			gen_string();
		end else if (r < 85) begin
			gen_composite($urandom_range(1, 6));
		end else if (r < 95) begin
			repeat ($urandom_range(1, 6))
				put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
					$urandom_range(0, 7) == 0);
		end else begin
			put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3))
				put_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void gen_directed();
		put_byte(8'h00);
		put_byte(8'hFF, 1'b1, 1'b1);
		put_byte("7", 1'b1);
		put_byte(CH_COMMA);
		put_byte("t", 1'b1);
		put_byte(8'h00, 1'b0, 1'b1);
		put_byte(CH_RBRACK, 1'b1);
		put_byte(CH_SPACE);
		put_byte(CH_QUOTE, 1'b1);
		put_byte("a");
		put_byte(CH_BSLASH);
		put_byte(CH_QUOTE);
		put_byte(8'hFF);
		put_byte(CH_QUOTE);
		put_byte(CH_QUOTE, 1'b1);
		put_byte(8'h00, 1'b0, 1'b1);
		put_byte(CH_LBRACE, 1'b1);
		put_byte(CH_QUOTE);
		put_byte(CH_RBRACE);
		put_byte(CH_QUOTE);
		put_byte(CH_LBRACK);
		put_byte(CH_RBRACK);
		put_byte(CH_RBRACE);
		put_byte(CH_LBRACK, 1'b1);
		put_byte(CH_RBRACE);
		put_byte(CH_LBRACE, 1'b1);
		put_byte("5", 1'b1);
		put_byte(CH_TAB);
		put_byte(CH_LBRACK, 1'b1);
		put_byte(8'hA5, 1'b0, 1'b1);
	endfunction

	task automatic send_byte(text_item_t it);
		int gap;
		gap = idling ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.data_byte    <= it.c;
		in_ch.start_value  <= it.st;
		in_ch.end_of_input <= it.eof;
		do begin
			@(posedge clk);
			if (!in_ch.ready)
				input_stalls++;
		end while (!in_ch.ready);
		board.take_byte(it.c, it.st, it.eof);
	endtask

	task automatic play_text();
		while (text_q.size() > 0)
			send_byte(text_q.pop_front());
		in_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (board.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [LEN_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_limit(v);
		limits_used++;
	endtask

	// result sink
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				gap      = HOLD_CYCLES;
				hold_req = 1'b0;
				holds_done++;
			end else begin
				gap = idling ? $urandom_range(0, 6) : 0;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!out_ch.valid);
			board.match_result(out_ch.byte_consumed, out_ch.value_done, out_ch.value_length,
				out_ch.status);
		end
	end

	initial begin
		logic [LEN_W-1:0] limits[7];
		int base;
		board        = new();
		idling       = 1'b1;
		hold_req     = 1'b0;
		holds_done   = 0;
		input_stalls = 0;
		limits_used  = 1;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.data_byte    <= '0;
		in_ch.start_value  <= 1'b0;
		in_ch.end_of_input <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gen_directed();
		play_text();
		settle();

		limits = '{28'd1, 28'd2, 28'd9, 28'd40, MAX_RESET, 28'd0, 28'd0};
		limits[6] = LEN_W'($urandom_range(100, MAX_RESET));
		for (int p = 0; p < 7; p++) begin
			write_limit(limits[p]);
			idling   = (p % 3) != 2;
			hold_req = (p == 1 || p == 4);
			if (limits[p] == MAX_RESET) begin
				gen_deep(1'b0);
				gen_deep(1'b1);
			end
			base = text_q.size();
			while (text_q.size() < base + PHASE_ITEMS)
				gen_value();
			play_text();
			settle();
		end

		$display("checked %0d result transactions under %0d length limits, %0d values ended",
			board.checked, limits_used, board.ended);
		$display("status codes seen %b, %0d long holds, %0d cycles of input back-pressure",
			board.status_seen, holds_done, input_stalls);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
